FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, quiet while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising clk edge
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int IDX_W       = 8;
	localparam int CH_W        = 8;
	localparam int ERR_W       = 10;
	localparam int ERR_MAX     = 765;

	// word modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// gray level weights and reciprocal of the divisor
	localparam int W_R        = 30;
	localparam int W_G        = 59;
	localparam int W_B        = 10;
	localparam int GRAY_DIV   = 100;
	localparam int DIV_SHIFT  = 22;
	localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + GRAY_DIV - 1) / GRAY_DIV;
	localparam int TINT_SHIFT = 6;
	localparam int TQ_W       = 6;

	// shared multiply-add unit
	localparam int MAC_IN_W  = 16;
	localparam int MAC_OUT_W = 32;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic              en;
		logic              first;
		logic [PAL_AW-1:0] idx;
	} scan_ctl_t;

	function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

FILE: sv/tinted_palette_remap.sv
// Write word: taken while idle, and the next word may follow at once.
// Query word: ready drops after acceptance and returns once the result is loaded;
// the steps are the source entry read, seven multiply-add set-up steps, the tint
// capture, the palette scan at one entry per cycle, the scan drain and the output
// load, which waits while an earlier result is still held and not taken.
// Reset (arst_n low, asynchronous) empties the palette to black and drops any result.
`default_nettype none

module tinted_palette_remap import tpr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             mode,
	input  wire logic [IDX_W-1:0] entry_index,
	input  wire logic [CH_W-1:0]  red,
	input  wire logic [CH_W-1:0]  green,
	input  wire logic [CH_W-1:0]  blue,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [IDX_W-1:0]      mapped_index,
	output logic [ERR_W-1:0]      match_error
);

`include "assert_macros.svh"

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_W0    = 4'd1;
	localparam logic [3:0] S_W1    = 4'd2;
	localparam logic [3:0] S_W2    = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_TR    = 4'd5;
	localparam logic [3:0] S_TG    = 4'd6;
	localparam logic [3:0] S_TB    = 4'd7;
	localparam logic [3:0] S_TC    = 4'd8;
	localparam logic [3:0] S_SCAN  = 4'd9;
	localparam logic [3:0] S_DRAIN = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]           state_q;
	logic [PAL_AW-1:0]    cnt_q;
	logic [TQ_W-1:0]      qr_q, qg_q, qb_q;
	logic [CH_W-1:0]      gray_q;
	rgb_t                 tint_q;
	scan_ctl_t            scan_s1;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     mapped_index_q;
	logic [ERR_W-1:0]     match_error_q;

	logic                 in_acc;
	logic                 wr_word;
	logic                 qry_word;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	rgb_t                 src;
	logic                 mac_en;
	logic [MAC_IN_W-1:0]  mac_a, mac_b;
	logic [MAC_OUT_W-1:0] mac_c, mac_res;
	logic [CH_W-1:0]      gray_now;
	logic [CH_W-1:0]      tint_now;
	logic [IDX_W-1:0]     best_idx;
	logic [ERR_W-1:0]     best_err;
	logic                 out_load;
	logic                 scan_last;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wr_word  = in_acc && (mode == MODE_WRITE);
	assign qry_word = in_acc && (mode == MODE_QUERY);

	// palette read port: source entry on query, then the scan
	assign rd_en   = qry_word || (state_q == S_SCAN);
	assign rd_addr = (state_q == S_SCAN) ? IDX_W'(cnt_q) : entry_index;

	tpr_pal u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_word),
		.wr_addr (entry_index),
		.wr_data ({red, green, blue}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (src)
	);

	// field views of the shared unit's result
	assign gray_now = mac_res[DIV_SHIFT+CH_W-1:DIV_SHIFT];
	assign tint_now = mac_res[TINT_SHIFT+CH_W-1:TINT_SHIFT];

	// operand selection for the shared multiply-add unit
	always_comb begin
		mac_en = 1'b1;
		mac_a  = '0;
		mac_b  = '0;
		mac_c  = '0;
		case (state_q)
			S_W0: begin
				mac_a = MAC_IN_W'(src.r);
				mac_b = MAC_IN_W'(W_R);
			end
			S_W1: begin
				mac_a = MAC_IN_W'(src.g);
				mac_b = MAC_IN_W'(W_G);
				mac_c = mac_res;
			end
			S_W2: begin
				mac_a = MAC_IN_W'(src.b);
				mac_b = MAC_IN_W'(W_B);
				mac_c = mac_res;
			end
			S_DIV: begin
				mac_a = mac_res[MAC_IN_W-1:0];
				mac_b = MAC_IN_W'(DIV_RECIP);
			end
			S_TR: begin
				mac_a = MAC_IN_W'(gray_now);
				mac_b = MAC_IN_W'(qr_q);
			end
			S_TG: begin
				mac_a = MAC_IN_W'(gray_q);
				mac_b = MAC_IN_W'(qg_q);
			end
			S_TB: begin
				mac_a = MAC_IN_W'(gray_q);
				mac_b = MAC_IN_W'(qb_q);
			end
			default: mac_en = 1'b0;
		endcase
	end

	tpr_mac u_mac (
		.clk   (clk),
		.en    (mac_en),
		.op_a  (mac_a),
		.op_b  (mac_b),
		.op_c  (mac_c),
		.res_q (mac_res)
	);

	tpr_scan u_scan (
		.clk      (clk),
		.ctl      (scan_s1),
		.tint     (tint_q),
		.entry    (src),
		.best_idx (best_idx),
		.best_err (best_err)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			scan_s1 <= '0;
		end else begin
			scan_s1.en    <= (state_q == S_SCAN);
			scan_s1.first <= (cnt_q == '0);
			scan_s1.idx   <= cnt_q;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (qry_word)
						state_q <= S_W0;
				end
				S_W0:  state_q <= S_W1;
				S_W1:  state_q <= S_W2;
				S_W2:  state_q <= S_DIV;
				S_DIV: state_q <= S_TR;
				S_TR:  state_q <= S_TG;
				S_TG:  state_q <= S_TB;
				S_TB:  state_q <= S_TC;
				S_TC:  state_q <= S_SCAN;
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == PAL_AW'(PAL_ENTRIES - 1))
						state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// tint quotients, gray level and tinted colour
	always_ff @(posedge clk) begin
		if (qry_word) begin
			qr_q <= red[CH_W-1:CH_W-TQ_W];
			qg_q <= green[CH_W-1:CH_W-TQ_W];
			qb_q <= blue[CH_W-1:CH_W-TQ_W];
		end
		if (state_q == S_TR)
			gray_q <= gray_now;
		if (state_q == S_TG)
			tint_q.r <= tint_now;
		if (state_q == S_TB)
			tint_q.g <= tint_now;
		if (state_q == S_TC)
			tint_q.b <= tint_now;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mapped_index_q <= best_idx;
			match_error_q  <= best_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_index = mapped_index_q;
	assign match_error  = match_error_q;

	// last scan step in flight
	assign scan_last = scan_s1.en && (scan_s1.idx == PAL_AW'(PAL_ENTRIES - 1));

	// checks
	`ASSERT_NEXT(a_query_busy, qry_word, !in_ready, "ready still high after a query word")
	`ASSERT_IMPL(a_out_from_done, $rose(out_valid), $past(state_q) == S_DONE, "result not from done")
	`ASSERT_IMPL(a_drain_last, state_q == S_DRAIN, scan_last, "scan did not end on the last entry")
	`ASSERT_CLK(a_err_range, !out_valid || (match_error <= ERR_W'(ERR_MAX)), "match error out of range")

endmodule

`default_nettype wire

FILE: sv/tpr_pal.sv
`default_nettype none

module tpr_pal import tpr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire rgb_t             wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output rgb_t                  rd_data
);

	logic [PAL_ENTRIES-1:0] vld_q;
	rgb_t                   mem_q [PAL_ENTRIES];
	rgb_t                   rd_raw_q;
	logic                   rd_hit_q;
	logic                   wr_ok;
	logic                   rd_ok;

	// addresses beyond the palette are dropped on write and read as black
	assign wr_ok = wr_en && ({1'b0, wr_addr} < (IDX_W+1)'(PAL_ENTRIES));
	assign rd_ok = {1'b0, rd_addr} < (IDX_W+1)'(PAL_ENTRIES);

	// per-entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_ok)
				vld_q[wr_addr[PAL_AW-1:0]] <= 1'b1;
			if (rd_en)
				rd_hit_q <= rd_ok && vld_q[rd_addr[PAL_AW-1:0]];
		end
	end

	// storage array, registered read
	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[wr_addr[PAL_AW-1:0]] <= wr_data;
		if (rd_en)
			rd_raw_q <= mem_q[rd_addr[PAL_AW-1:0]];
	end

	assign rd_data = rd_hit_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

FILE: sv/tpr_mac.sv
`default_nettype none

module tpr_mac import tpr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [MAC_IN_W-1:0]  op_a,
	input  wire logic [MAC_IN_W-1:0]  op_b,
	input  wire logic [MAC_OUT_W-1:0] op_c,
	output logic [MAC_OUT_W-1:0]      res_q
);

	logic [MAC_OUT_W-1:0] prod;

	// full-width product of the two operands
	assign prod = {{(MAC_OUT_W-MAC_IN_W){1'b0}}, op_a} * {{(MAC_OUT_W-MAC_IN_W){1'b0}}, op_b};

	// res = a * b + c, one step per cycle while en is high
	always_ff @(posedge clk) begin
		if (en)
			res_q <= prod + op_c;
	end

endmodule

`default_nettype wire

FILE: sv/tpr_scan.sv
`default_nettype none

module tpr_scan import tpr_pkg::*; (
	input  wire logic      clk,
	input  wire scan_ctl_t ctl,
	input  wire rgb_t      tint,
	input  wire rgb_t      entry,
	output logic [IDX_W-1:0] best_idx,
	output logic [ERR_W-1:0] best_err
);

	logic [PAL_AW-1:0] best_idx_q;
	logic [ERR_W-1:0]  best_err_q;
	logic [ERR_W-1:0]  err;

	// L1 distance of the current entry to the tinted colour
	assign err = ERR_W'(absdiff(tint.r, entry.r)) + ERR_W'(absdiff(tint.g, entry.g))
		+ ERR_W'(absdiff(tint.b, entry.b));

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.first || err < best_err_q)) begin
			best_idx_q <= ctl.idx;
			best_err_q <= err;
		end
	end

	assign best_idx = IDX_W'(best_idx_q);
	assign best_err = best_err_q;

endmodule

`default_nettype wire

FILE: tb/tinted_palette_remap_checker.sv
module tinted_palette_remap_checker import tpr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire logic             mode,
	input  wire logic [IDX_W-1:0] entry_index,
	input  wire logic [CH_W-1:0]  red,
	input  wire logic [CH_W-1:0]  green,
	input  wire logic [CH_W-1:0]  blue,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire logic [IDX_W-1:0] mapped_index,
	input  wire logic [ERR_W-1:0] match_error,
	output int                    failures,
	output int                    pending,
	output int                    results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// luminance weights, divisor and tint scaling
	localparam int unsigned LUMA_R   = 30;
	localparam int unsigned LUMA_G   = 59;
	localparam int unsigned LUMA_B   = 10;
	localparam int unsigned LUMA_DIV = 100;
	localparam int unsigned TINT_SH  = 6;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [ERR_W-1:0] err;
	} match_t;

	// shadow palette and the remap results still owed by the block
	rgb_t   shades [PAL_ENTRIES];
	match_t awaited [$];

	function automatic int unsigned chan_gap(input int unsigned a, input int unsigned b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// grey of the source entry, tinted per channel, then an L1 scan of the palette
	function automatic match_t nearest_tinted(input rgb_t src, input rgb_t tint);
		int unsigned grey, tr, tg, tb, gap, best_err;
		int          best;
		match_t      found;
		grey = (LUMA_R * src.r + LUMA_G * src.g + LUMA_B * src.b) / LUMA_DIV;
		tr = (grey * (int'(tint.r) >> 2)) >> TINT_SH;
		tg = (grey * (int'(tint.g) >> 2)) >> TINT_SH;
		tb = (grey * (int'(tint.b) >> 2)) >> TINT_SH;
		best = 0;
		best_err = 32'hFFFF_FFFF;
		for (int k = 0; k < PAL_ENTRIES; k++) begin
			gap = chan_gap(tr, shades[k].r) + chan_gap(tg, shades[k].g)
				+ chan_gap(tb, shades[k].b);
			// strict compare keeps the lowest index on ties
			if (gap < best_err) begin
				best_err = gap;
				best = k;
			end
		end
		found.index = best[IDX_W-1:0];
		found.err = best_err[ERR_W-1:0];
		return found;
	endfunction

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		match_t want;
		if (!arst_n) begin
			for (int k = 0; k < PAL_ENTRIES; k++)
				shades[k] = '0;
			awaited.delete();
			failures = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (mode == MODE_WRITE)
					shades[entry_index] = {red, green, blue};
				else
					awaited.push_back(nearest_tinted(shades[entry_index], {red, green, blue}));
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result word, index %0d error %0d",
							$time, mapped_index, match_error);
				end else begin
					want = awaited.pop_front();
					if (mapped_index !== want.index || match_error !== want.err) begin
						failures++;
						if (failures <= 10)
							$display("%0t: remap mismatch, expected index %0d error %0d, got index %0d error %0d",
								$time, want.index, want.err, mapped_index, match_error);
					end
				end
			end
			pending = awaited.size();
		end
	end

endmodule

FILE: tb/tinted_palette_remap_test.sv
module tinted_palette_remap_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tpr_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = MODE_WRITE;
	logic [IDX_W-1:0] entry_index = '0;
	logic [CH_W-1:0]  red = '0;
	logic [CH_W-1:0]  green = '0;
	logic [CH_W-1:0]  blue = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] mapped_index;
	logic [ERR_W-1:0] match_error;

	int   failures, pending, results_seen;
	int   writes_sent = 0;
	int   queries_sent = 0;
	bit   steady = 1'b0;
	rgb_t lately_written = '0;

	tinted_palette_remap i_dut (.*);

	tinted_palette_remap_checker i_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// give up long after the slowest legal run
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// result side back-pressure
	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 32);

	// one word on the input channel; returns at the falling edge after acceptance
	task automatic send_word(input logic m, input logic [IDX_W-1:0] idx, input rgb_t c);
		while (!steady && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		red <= c.r;
		green <= c.g;
		blue <= c.b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (m == MODE_WRITE) begin
			writes_sent++;
			lately_written = c;
		end else begin
			queries_sent++;
		end
	endtask

	// tint byte with a bias towards the extremes
	function automatic logic [CH_W-1:0] tint_byte();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic rgb_t any_colour();
		return {8'($urandom), 8'($urandom), 8'($urandom)};
	endfunction

	initial begin
		int unsigned sel;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: black palette after reset
		send_word(MODE_QUERY, 8'd0, 24'hFFFFFF);
		// primaries, white, mid grey and alternating bit patterns
		send_word(MODE_WRITE, 8'd255, 24'hFFFFFF);
		send_word(MODE_WRITE, 8'd1, 24'hFF0000);
		send_word(MODE_WRITE, 8'd2, 24'h00FF00);
		send_word(MODE_WRITE, 8'd3, 24'h0000FF);
		send_word(MODE_WRITE, 8'd128, 24'h808080);
		send_word(MODE_WRITE, 8'd254, 24'hAA55AA);
		send_word(MODE_QUERY, 8'd255, 24'hFFFFFF);
		send_word(MODE_QUERY, 8'd255, 24'h000000);
		// each channel paired with its own tint byte
		send_word(MODE_QUERY, 8'd1, 24'hFF0000);
		send_word(MODE_QUERY, 8'd2, 24'h00FF00);
		send_word(MODE_QUERY, 8'd3, 24'h0000FF);
		// low tint bits drop out of the quotient
		send_word(MODE_QUERY, 8'd255, 24'h0304FC);
		send_word(MODE_QUERY, 8'd254, 24'h55AA55);
		// duplicate white: lowest index wins the tie
		send_word(MODE_WRITE, 8'd0, 24'hFFFFFF);
		send_word(MODE_QUERY, 8'd255, 24'hFFFFFF);
		// never-written source reads as black, nearest black entry lies above the primaries
		send_word(MODE_QUERY, 8'd200, 24'hFFFFFF);
		send_word(MODE_QUERY, 8'd128, 24'h7F80FF);

		// sweep the whole palette, first half without any idling
		for (int k = 0; k < PAL_ENTRIES; k++) begin
			steady = (k < 128);
			send_word(MODE_WRITE, 8'(k), any_colour());
			if (k % 16 == 15)
				send_word(MODE_QUERY, 8'($urandom_range(0, k)),
					{tint_byte(), tint_byte(), tint_byte()});
		end
		steady = 1'b0;

		// hold off until the block has delivered everything owed
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);

		// mixed traffic: queries, fresh colours and repeated colours for ties
		for (int n = 0; n < 310; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				send_word(MODE_QUERY, 8'($urandom),
					{tint_byte(), tint_byte(), tint_byte()});
			else if (sel < 60)
				send_word(MODE_WRITE, 8'($urandom), lately_written);
			else
				send_word(MODE_WRITE, 8'($urandom), any_colour());
		end

		// drain and verdict
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (300) @(posedge clk);
		$display("Sent %0d palette writes and %0d tinted queries; %0d remap results compared.",
			writes_sent, queries_sent, results_seen);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
